// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Implication whose consequence is checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== rtl/core/brs_pkg.sv =====
// Package: constants, types and helpers of the bilinear sampler.
package brs_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int FracBits  = 8;
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int RowBits   = $clog2(MaxHeight);
    localparam int AddrBits  = ColBits + RowBits;
    localparam int Depth     = MaxWidth * MaxHeight;
    localparam int CoordBits = 17;
    localparam int IntBits   = CoordBits - FracBits;
    localparam int SizeBits  = 9;
    localparam int CfgIdxBits = 1;
    localparam int WtBits    = FracBits + 1;
    localparam int ProdBits  = 2 * WtBits + 8;
    localparam int SumBits   = ProdBits + 2;

    localparam logic [CfgIdxBits-1:0] RegWidth  = 1'd0;
    localparam logic [CfgIdxBits-1:0] RegHeight = 1'd1;
    localparam logic FuncWrite  = 1'b0;
    localparam logic FuncSample = 1'b1;

    typedef logic [AddrBits-1:0] addr_t;

    // Sample item after address generation.
    typedef struct packed {
        logic                hit;
        logic [FracBits-1:0] a;
        logic [FracBits-1:0] b;
    } samp_t;
endpackage

// ===== rtl/core/brs_ram.sv =====
// Generic single-write, single-read RAM with registered read.
module brs_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/brs_addr.sv =====
// Address stage: floor/ceil, footprint test and edge wrap.
module brs_addr (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [brs_pkg::CoordBits-1:0] u,
    input  logic signed [brs_pkg::CoordBits-1:0] v,
    input  logic [brs_pkg::SizeBits-1:0]      width_cfg,
    input  logic [brs_pkg::SizeBits-1:0]      height_cfg,
    output logic                              out_valid,
    output brs_pkg::samp_t                    samp,
    output brs_pkg::addr_t                    addr00,
    output brs_pkg::addr_t                    addr10,
    output brs_pkg::addr_t                    addr01,
    output brs_pkg::addr_t                    addr11
);
    import brs_pkg::*;

    localparam int EB = IntBits + 2;

    logic [SizeBits-1:0] w_eff, h_eff;
    logic signed [EB-1:0] x1, y1, x2, y2, wm1, hm1, ws, hs;
    logic [FracBits-1:0] a, b;
    logic                hit;
    logic [ColBits-1:0]  cx1, cx2;
    logic [RowBits-1:0]  ry1, ry2;
    logic                valid_reg;
    samp_t               samp_reg;
    addr_t a00_reg, a10_reg, a01_reg, a11_reg;

    always_comb
    begin
        w_eff = (width_cfg == '0) ? SizeBits'(1)
              : (width_cfg > SizeBits'(MaxWidth)) ? SizeBits'(MaxWidth) : width_cfg;
        h_eff = (height_cfg == '0) ? SizeBits'(1)
              : (height_cfg > SizeBits'(MaxHeight)) ? SizeBits'(MaxHeight) : height_cfg;
        ws  = EB'(signed'({1'b0, w_eff}));
        hs  = EB'(signed'({1'b0, h_eff}));
        wm1 = ws - EB'(1);
        hm1 = hs - EB'(1);
        a   = u[FracBits-1:0];
        b   = v[FracBits-1:0];
        x1  = EB'(signed'(u[CoordBits-1:FracBits]));
        y1  = EB'(signed'(v[CoordBits-1:FracBits]));
        x2  = x1 + EB'(a != '0);
        y2  = y1 + EB'(b != '0);
        hit = !(x2 < 0 || x1 > wm1 || y2 < 0 || y1 > hm1);
        cx1 = ColBits'((x1 < 0) ? x1 + ws : x1);
        ry1 = RowBits'((y1 < 0) ? y1 + hs : y1);
        cx2 = ColBits'((x2 >= ws) ? x2 - ws : x2);
        ry2 = RowBits'((y2 >= hs) ? y2 - hs : y2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            samp_reg <= '{hit: hit, a: a, b: b};
            a00_reg  <= {ry1, cx1};
            a10_reg  <= {ry1, cx2};
            a01_reg  <= {ry2, cx1};
            a11_reg  <= {ry2, cx2};
        end
    end

    assign out_valid = valid_reg;
    assign samp      = samp_reg;
    assign addr00    = a00_reg;
    assign addr10    = a10_reg;
    assign addr01    = a01_reg;
    assign addr11    = a11_reg;
endmodule

// ===== rtl/core/brs_blend.sv =====
// Blend stages: weighted products, sums and rounding for four channels.
module brs_blend (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  brs_pkg::samp_t        samp,
    input  logic [31:0]           p00,
    input  logic [31:0]           p10,
    input  logic [31:0]           p01,
    input  logic [31:0]           p11,
    output logic                  out_valid,
    output logic                  hit,
    output logic [31:0]           rgba
);
    import brs_pkg::*;

    localparam int WwBits = 2 * WtBits;
    localparam logic [SumBits-1:0] Half = SumBits'(1) << (2 * FracBits - 1);

    // Stage W: weights.
    logic                v1_reg, v2_reg, v3_reg;
    logic                h1_reg, h2_reg, h3_reg;
    logic [WwBits-1:0]   w_reg [4];
    logic [31:0]         px1_reg [4];
    logic [ProdBits-1:0] prod_reg [4][4];
    logic [31:0]         out_reg;
    logic [WtBits-1:0]   ia, ib, aa, bb;
    logic [SumBits-1:0]  sum [4];

    assign aa = WtBits'(samp.a);
    assign bb = WtBits'(samp.b);
    assign ia = WtBits'(1 << FracBits) - aa;
    assign ib = WtBits'(1 << FracBits) - bb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = SumBits'(prod_reg[0][c]) + SumBits'(prod_reg[1][c])
                   + SumBits'(prod_reg[2][c]) + SumBits'(prod_reg[3][c]) + Half;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg <= samp.hit;
            w_reg[0] <= ia * ib;
            w_reg[1] <= aa * ib;
            w_reg[2] <= ia * bb;
            w_reg[3] <= aa * bb;
            px1_reg[0] <= p00;
            px1_reg[1] <= p10;
            px1_reg[2] <= p01;
            px1_reg[3] <= p11;
            h2_reg <= h1_reg;
            for (int t = 0; t < 4; t++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[t][c] <= ProdBits'(w_reg[t]) * ProdBits'(px1_reg[t][8*c +: 8]);
                end
            end
            h3_reg <= h2_reg;
            for (int c = 0; c < 4; c++)
            begin
                out_reg[8*c +: 8] <= h2_reg ? sum[c][2*FracBits +: 8] : 8'd0;
            end
        end
    end

    assign out_valid = v3_reg;
    assign hit       = h3_reg;
    assign rgba      = out_reg;
endmodule

// ===== rtl/core/bilinear_rgba_sampler_wrap_core.sv =====
// Top level: bilinear RGBA8 sampler with edge wrap and texel store.
//
//  channel | signals                                   | dir
//  in      | in_valid/in_ready, func..v_coord          | beat in
//  out     | out_valid/out_ready, hit, red..alpha      | beat out
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//
// One beat per clock unless out_ready stalls; a sample passes 5 register stages
// to the output register (address, RAM read, weights, products, sum). The store
// is four RAM copies so the four neighbors read in the same cycle. Reset clears
// valid bits, sets the size registers to 256 x 256; the store is not cleared.
// A stall of out_ready freezes the whole pipe; nothing is lost or repeated.
module bilinear_rgba_sampler_wrap_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [brs_pkg::CfgIdxBits-1:0]         cfg_index,
    input  logic [brs_pkg::SizeBits-1:0]           cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   func,
    input  logic [7:0]                             texel_col,
    input  logic [7:0]                             texel_row,
    input  logic [31:0]                            texel_rgba,
    input  logic signed [brs_pkg::CoordBits-1:0]   u_coord,
    input  logic signed [brs_pkg::CoordBits-1:0]   v_coord,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   hit,
    output logic [7:0]                             red,
    output logic [7:0]                             green,
    output logic [7:0]                             blue,
    output logic [7:0]                             alpha
);
    import brs_pkg::*;

    logic [SizeBits-1:0] width_reg, height_reg;
    logic   en, acc, wr, smp;
    logic   a_valid, r_valid_reg, b_valid;
    samp_t  a_samp, r_samp_reg;
    addr_t  a00, a10, a01, a11;
    logic [31:0] q00, q10, q01, q11, rgba;
    addr_t  waddr;

    // Advance whenever the output slot is free or being drained.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign acc      = in_valid && in_ready;
    assign wr       = acc && (func == FuncWrite);
    assign smp      = acc && (func == FuncSample);
    assign waddr    = {RowBits'(texel_row), ColBits'(texel_col)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SizeBits'(MaxWidth);
            height_reg <= SizeBits'(MaxHeight);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegWidth:  width_reg  <= cfg_data;
                RegHeight: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    brs_addr u_addr (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(smp),
        .u(u_coord), .v(v_coord), .width_cfg(width_reg), .height_cfg(height_reg),
        .out_valid(a_valid), .samp(a_samp),
        .addr00(a00), .addr10(a10), .addr01(a01), .addr11(a11)
    );

    // Four store copies, written together; each serves one neighbor.
    brs_ram #(.Width(32), .Depth(Depth)) u_ram00 (
        .clk(clk), .we(wr), .waddr(waddr), .wdata(texel_rgba),
        .re(en), .raddr(a00), .rdata(q00));
    brs_ram #(.Width(32), .Depth(Depth)) u_ram10 (
        .clk(clk), .we(wr), .waddr(waddr), .wdata(texel_rgba),
        .re(en), .raddr(a10), .rdata(q10));
    brs_ram #(.Width(32), .Depth(Depth)) u_ram01 (
        .clk(clk), .we(wr), .waddr(waddr), .wdata(texel_rgba),
        .re(en), .raddr(a01), .rdata(q01));
    brs_ram #(.Width(32), .Depth(Depth)) u_ram11 (
        .clk(clk), .we(wr), .waddr(waddr), .wdata(texel_rgba),
        .re(en), .raddr(a11), .rdata(q11));

    // Hold sample info alongside the RAM read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_samp_reg <= a_samp;
        end
    end

    brs_blend u_blend (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r_valid_reg),
        .samp(r_samp_reg), .p00(q00), .p10(q10), .p01(q01), .p11(q11),
        .out_valid(b_valid), .hit(hit), .rgba(rgba)
    );

    assign out_valid = b_valid;
    assign red   = rgba[7:0];
    assign green = rgba[15:8];
    assign blue  = rgba[23:16];
    assign alpha = rgba[31:24];
endmodule

// ===== rtl/core/brs_checker.sv =====
// Port-level checker for the sampler, bound to the top level.
`include "assert_macros.svh"
module brs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       hit,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha
);
    `CHK_IMPLY(a_miss_zero, clk, rst_n, out_valid && !hit,
        red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(hit) && $stable(red) && $stable(alpha))
    `CHK_IMPLY(a_ready_free, clk, rst_n, !out_valid || out_ready, in_ready)
    `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
endmodule

bind bilinear_rgba_sampler_wrap_core brs_checker u_brs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .red(red), .green(green), .blue(blue), .alpha(alpha)
);

// ===== tb/sv/tb_bilinear_rgba_sampler_wrap_core.sv =====
// Testbench for the bilinear RGBA8 wrap sampler: directed table plus random beats.
module tb_bilinear_rgba_sampler_wrap_core;
    import brs_pkg::*;

    // One input beat as driven on the in channel.
    typedef struct {
        logic                        func;
        logic [7:0]                  col;
        logic [7:0]                  row;
        logic [31:0]                 rgba;
        logic signed [CoordBits-1:0] u;
        logic signed [CoordBits-1:0] v;
        bit                          fixed;   // result typed in the table
        logic [32:0]                 want;    // {hit, alpha, blue, green, red}
    } beat_t;

    // One sampled texel as seen on the out channel.
    typedef struct {
        logic       hit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } texel_out_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CfgIdxBits-1:0]       cfg_index;
    logic [SizeBits-1:0]         cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        func;
    logic [7:0]                  texel_col;
    logic [7:0]                  texel_row;
    logic [31:0]                 texel_rgba;
    logic signed [CoordBits-1:0] u_coord;
    logic signed [CoordBits-1:0] v_coord;
    logic                        out_valid;
    logic                        out_ready;
    logic                        hit;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;
    logic [7:0]                  alpha;

    bilinear_rgba_sampler_wrap_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .texel_col(texel_col), .texel_row(texel_row),
        .texel_rgba(texel_rgba), .u_coord(u_coord), .v_coord(v_coord),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .red(red), .green(green), .blue(blue), .alpha(alpha)
    );

    // Shadow of the block: texel store, which entries are written, sizes.
    logic [31:0]   shadow_store [Depth];
    bit            stimulus_wrote [Depth];
    logic [8:0]    width_reg;
    logic [8:0]    height_reg;

    beat_t         pending_beats [$];
    texel_out_t    expected_texels [$];
    bit            idle_enable;
    int            mismatches;
    int            samples_seen;
    int            hits_seen;
    int            writes_sent;

    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("timeout: pipe never drained");
        $display("** bilinear_rgba_sampler_wrap_core: FAILED **");
        $finish;
    end

    function automatic int eff_size(logic [8:0] reg_val, int limit);
        if (reg_val == 0) return 1;
        if (reg_val > limit) return limit;
        return reg_val;
    endfunction

    // Find the 2x2 footprint after wrap; return 0 when it misses the image.
    function automatic bit footprint(int uu, int vv, output int x1, output int x2,
                                     output int y1, output int y2);
        int w;
        int h;
        w  = eff_size(width_reg, MaxWidth);
        h  = eff_size(height_reg, MaxHeight);
        x1 = uu >>> FracBits;
        y1 = vv >>> FracBits;
        x2 = x1 + ((uu & 255) != 0);
        y2 = y1 + ((vv & 255) != 0);
        if (x2 < 0 || x1 > w - 1 || y2 < 0 || y1 > h - 1) return 0;
        if (x1 < 0) x1 = w + x1;
        if (y1 < 0) y1 = h + y1;
        if (x2 >= w) x2 = x2 - w;
        if (y2 >= h) y2 = y2 - h;
        return 1;
    endfunction

    // Bilinear blend of the four neighbors, rounded half up.
    function automatic texel_out_t blend_sample(int uu, int vv);
        texel_out_t r;
        int x1, x2, y1, y2;
        longint unsigned a, b, acc;
        logic [31:0] p00, p10, p01, p11;
        logic [7:0] chan [4];
        r = '{default: '0};
        if (!footprint(uu, vv, x1, x2, y1, y2)) return r;
        a   = uu & 255;
        b   = vv & 255;
        p00 = shadow_store[y1 * MaxWidth + x1];
        p10 = shadow_store[y1 * MaxWidth + x2];
        p01 = shadow_store[y2 * MaxWidth + x1];
        p11 = shadow_store[y2 * MaxWidth + x2];
        for (int c = 0; c < 4; c++)
        begin
            acc = (256 - a) * (256 - b) * p00[c*8 +: 8] + a * (256 - b) * p10[c*8 +: 8]
                + (256 - a) * b * p01[c*8 +: 8] + a * b * p11[c*8 +: 8] + 32768;
            chan[c] = acc[23:16];
        end
        r.hit   = 1'b1;
        r.red   = chan[0];
        r.green = chan[1];
        r.blue  = chan[2];
        r.alpha = chan[3];
        return r;
    endfunction

    task automatic queue_write(int cx, int ry, logic [31:0] px);
        beat_t bt;
        bt.func  = FuncWrite;
        bt.col   = 8'(cx);
        bt.row   = 8'(ry);
        bt.rgba  = px;
        bt.u     = CoordBits'($urandom);
        bt.v     = CoordBits'($urandom);
        bt.fixed = 0;
        bt.want  = '0;
        stimulus_wrote[ry * MaxWidth + cx] = 1;
        pending_beats.push_back(bt);
    endtask

    // Queue a sample; first fill any neighbor the stimulus never wrote.
    task automatic queue_sample(int uu, int vv, bit fixed, logic [32:0] want);
        beat_t bt;
        int x1, x2, y1, y2;
        if (footprint(uu, vv, x1, x2, y1, y2))
        begin
            if (!stimulus_wrote[y1 * MaxWidth + x1]) queue_write(x1, y1, $urandom);
            if (!stimulus_wrote[y1 * MaxWidth + x2]) queue_write(x2, y1, $urandom);
            if (!stimulus_wrote[y2 * MaxWidth + x1]) queue_write(x1, y2, $urandom);
            if (!stimulus_wrote[y2 * MaxWidth + x2]) queue_write(x2, y2, $urandom);
        end
        bt.func  = FuncSample;
        bt.col   = 8'($urandom);
        bt.row   = 8'($urandom);
        bt.rgba  = $urandom;
        bt.u     = CoordBits'(uu);
        bt.v     = CoordBits'(vv);
        bt.fixed = fixed;
        bt.want  = want;
        pending_beats.push_back(bt);
    endtask

    // Input side: accept, update the shadow, present the next beat.
    always @(posedge clk)
    begin
        beat_t bt;
        texel_out_t t;
        bit took;
        if (rst_n)
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                if (func == FuncWrite)
                begin
                    shadow_store[{texel_row, texel_col}] = texel_rgba;
                    writes_sent++;
                end
                else
                begin
                    t = blend_sample(u_coord, v_coord);
                    bt = pending_beats[0];
                    expected_texels.push_back(t);
                end
            end
            if (!in_valid || took)
            begin
                if (took) void'(pending_beats.pop_front());
                if (pending_beats.size() > 0 && !(idle_enable && $urandom_range(99) < 20))
                begin
                    bt = pending_beats[0];
                    // Expectations come from the shadow also for typed rows; check_typed checks those.
                    if (bt.fixed) pending_beats[0].fixed = 1;
                    in_valid   <= 1'b1;
                    func       <= bt.func;
                    texel_col  <= bt.col;
                    texel_row  <= bt.row;
                    texel_rgba <= bt.rgba;
                    u_coord    <= bt.u;
                    v_coord    <= bt.v;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    // Directed rows with a typed result: check the shadow agrees after the table drains.
    task automatic check_typed(logic [32:0] want, int uu, int vv);
        texel_out_t t;
        t = blend_sample(uu, vv);
        if ({t.hit, t.alpha, t.blue, t.green, t.red} !== want)
            note_mismatch($sformatf("table row u=%0d v=%0d want %h got %h", uu, vv, want,
                                    {t.hit, t.alpha, t.blue, t.green, t.red}));
    endtask

    // Output side: compare every beat with the oldest expectation, stall at random when idle_enable is set.
    always @(posedge clk)
    begin
        texel_out_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_texels.size() == 0)
                    note_mismatch("result beat with nothing expected");
                else
                begin
                    e = expected_texels.pop_front();
                    samples_seen++;
                    hits_seen += hit;
                    if (hit !== e.hit || red !== e.red || green !== e.green
                        || blue !== e.blue || alpha !== e.alpha)
                        note_mismatch($sformatf(
                            "exp hit=%b rgba=%h_%h_%h_%h got hit=%b rgba=%h_%h_%h_%h",
                            e.hit, e.alpha, e.blue, e.green, e.red,
                            hit, alpha, blue, green, red));
                end
            end
            out_ready <= !(idle_enable && $urandom_range(99) < 20);
        end
    end

    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == RegWidth) width_reg = val;
        else height_reg = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every beat is in and every result is out, then let the pipe settle.
    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || expected_texels.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int w, h;
        w = eff_size(width_reg, MaxWidth);
        h = eff_size(height_reg, MaxHeight);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2: queue_write($urandom_range(255), $urandom_range(255), $urandom);
                3:       queue_sample($signed(17'($urandom)), $signed(17'($urandom)), 0, '0);
                default: queue_sample($urandom_range((w + 2) * 256) - 512,
                                      $urandom_range((h + 2) * 256) - 512, 0, '0);
            endcase
        end
    endtask

    // Directed table: func, col, row, rgba, u, v, typed?, {hit,a,b,g,r}.
    typedef struct {
        logic        func;
        int          col;
        int          row;
        logic [31:0] rgba;
        int          u;
        int          v;
        bit          fixed;
        logic [32:0] want;
    } row_t;

    row_t directed [] = '{
        '{FuncWrite,  0,   0,   32'h11223344, 0,      0,      0, '0},
        '{FuncSample, 0,   0,   0,            0,      0,      1, 33'h1_11223344},
        '{FuncWrite,  255, 255, 32'hFFFFFFFF, 0,      0,      0, '0},
        '{FuncSample, 0,   0,   0,            65280,  65280,  1, 33'h1_FFFFFFFF},
        '{FuncWrite,  1,   0,   32'h00000000, 0,      0,      0, '0},
        '{FuncSample, 0,   0,   0,            -65536, 0,      1, '0},
        '{FuncSample, 0,   0,   0,            0,      -65536, 1, '0},
        '{FuncSample, 0,   0,   0,            65535,  65535,  0, '0},
        '{FuncSample, 0,   0,   0,            -257,   0,      1, '0},
        '{FuncSample, 0,   0,   0,            128,    0,      0, '0},
        '{FuncSample, 0,   0,   0,            -1,     0,      0, '0},
        '{FuncSample, 0,   0,   0,            0,      -1,     0, '0},
        '{FuncSample, 0,   0,   0,            65281,  65281,  0, '0},
        '{FuncSample, 0,   0,   0,            65535,  0,      0, '0},
        '{FuncSample, 0,   0,   0,            -1,     -1,     0, '0},
        '{FuncSample, 0,   0,   0,            255,    255,    0, '0}
    };

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = RegWidth;
        cfg_data    = '0;
        in_valid    = 1'b0;
        func        = FuncWrite;
        texel_col   = '0;
        texel_row   = '0;
        texel_rgba  = '0;
        u_coord     = '0;
        v_coord     = '0;
        out_ready   = 1'b0;
        idle_enable = 1'b1;
        width_reg   = 9'd256;
        height_reg  = 9'd256;
        mismatches  = 0;
        samples_seen = 0;
        hits_seen   = 0;
        writes_sent = 0;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes, table first; typed rows are also checked against the shadow.
        foreach (directed[i])
        begin
            if (directed[i].func == FuncWrite)
                queue_write(directed[i].col, directed[i].row, directed[i].rgba);
            else
                queue_sample(directed[i].u, directed[i].v, directed[i].fixed,
                             directed[i].want);
        end
        drain();
        foreach (directed[i])
            if (directed[i].fixed)
                check_typed(directed[i].want, directed[i].u, directed[i].v);
        random_phase(60);
        drain();

        // Sweep sizes: minimum, zero, odd small, oversize, long strips, max.
        write_reg(RegWidth, 9'd1);   write_reg(RegHeight, 9'd1);   random_phase(60); drain();
        write_reg(RegWidth, 9'd0);   write_reg(RegHeight, 9'd0);   random_phase(50); drain();
        write_reg(RegWidth, 9'd3);   write_reg(RegHeight, 9'd5);   random_phase(80); drain();
        write_reg(RegWidth, 9'd511); write_reg(RegHeight, 9'd300); random_phase(70); drain();
        idle_enable = 1'b0;
        write_reg(RegWidth, 9'd17);  write_reg(RegHeight, 9'd2);   random_phase(90); drain();
        idle_enable = 1'b1;
        write_reg(RegWidth, 9'd2);   write_reg(RegHeight, 9'd256); random_phase(70); drain();
        write_reg(RegWidth, 9'd256); write_reg(RegHeight, 9'd256); random_phase(60); drain();

        $display("covered %0d texel writes and %0d samples (%0d hits) over 8 size settings",
                 writes_sent, samples_seen, hits_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_texels.size() == 0)
            $display("** bilinear_rgba_sampler_wrap_core: PASSED **");
        else
            $display("** bilinear_rgba_sampler_wrap_core: FAILED **");
        $finish;
    end
endmodule
